/* src/rotate_points_about_bond_axis_macros.svh */
// Assertion macros shared by the bond-axis rotation block.
`ifndef ROTATE_POINTS_ABOUT_BOND_AXIS_MACROS_SVH
`define ROTATE_POINTS_ABOUT_BOND_AXIS_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define RPBA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define RPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rpba_pkg.sv */
// Shared types, constants and tables for the bond-axis rotation block.
`timescale 1ns / 1ps
package rpba_pkg;

    localparam int IDX_W  = 6;
    localparam int CFG_W  = 32;
    localparam int MAG_W  = 33;
    localparam int SUM_W  = 64;
    localparam int LEN_W  = 32;
    localparam int QUO_W  = 31;
    localparam int OPW    = 34;
    localparam int CORD_W = 34;
    localparam int MW     = 36;
    localparam int MAT_W  = 32;
    localparam int ACC_W  = 37;
    localparam int CMP_W  = 7;

    localparam logic [1:0] REG_ANGLE = 2'd0;
    localparam logic [1:0] REG_SIDE  = 2'd1;
    localparam logic [1:0] REG_PIVOT = 2'd2;
    localparam logic [1:0] REG_AXIS  = 2'd3;

    localparam logic signed [CORD_W-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [CORD_W-1:0] PI_Q29      = 34'sd1686629713;
    localparam logic signed [CORD_W-1:0] HALF_PI_Q29 = 34'sd843314857;
    localparam logic signed [CORD_W-1:0] GAIN_Q30    = 34'sd652032874;

    localparam logic [4:0] SQ_LAST     = 5'd2;
    localparam logic [4:0] SQRT_LAST   = 5'd31;
    localparam logic [4:0] DIV_LAST    = 5'd30;
    localparam logic [4:0] CORDIC_LAST = 5'd29;
    localparam logic [4:0] MUL_LAST    = 5'd14;
    localparam logic [4:0] MUL_B_FIRST = 5'd12;
    localparam logic [1:0] LANE_LAST   = 2'd2;

    typedef enum logic [4:0] {
        S_LOAD, S_RD_PIV, S_RD_AXIS, S_DIFF, S_CHECK, S_NORM, S_SQ, S_SQRT,
        S_DIV_INIT, S_DIV, S_DIV_END, S_CORDIC_INIT, S_CORDIC, S_CS, S_MUL,
        S_MAT, S_EM_RD, S_EM_CAP, S_EM_MUL, S_EM_ACC, S_EM_OUT, S_EM_WAIT
    } st_t;

    typedef enum logic [4:0] {
        OP_IDLE, OP_RD_PIV, OP_RD_AXIS, OP_DIFF, OP_CHECK, OP_NORM, OP_SQ,
        OP_SQRT, OP_DIV_INIT, OP_DIV, OP_DIV_END, OP_CORDIC_INIT, OP_CORDIC,
        OP_CS, OP_MUL, OP_MAT, OP_EM_RD, OP_EM_CAP, OP_EM_MUL, OP_EM_ACC,
        OP_EM_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] cnt;
        logic [1:0] sel;
        logic       load;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic ok_now;
        logic norm_done;
        logic move_now;
    } stat_t;

    // Arctangent of 2^-i in Q3.29.
    function automatic logic signed [CORD_W-1:0] atan_q29(input logic [4:0] i);
        logic signed [CORD_W-1:0] v;
        unique case (i)
            5'd0:  v = 34'sd421657428;
            5'd1:  v = 34'sd248918915;
            5'd2:  v = 34'sd131521918;
            5'd3:  v = 34'sd66762579;
            5'd4:  v = 34'sd33510843;
            5'd5:  v = 34'sd16771758;
            5'd6:  v = 34'sd8387925;
            5'd7:  v = 34'sd4194219;
            5'd8:  v = 34'sd2097141;
            5'd9:  v = 34'sd1048575;
            5'd10: v = 34'sd524288;
            5'd11: v = 34'sd262144;
            5'd12: v = 34'sd131072;
            5'd13: v = 34'sd65536;
            5'd14: v = 34'sd32768;
            5'd15: v = 34'sd16384;
            5'd16: v = 34'sd8192;
            5'd17: v = 34'sd4096;
            5'd18: v = 34'sd2048;
            5'd19: v = 34'sd1024;
            5'd20: v = 34'sd512;
            5'd21: v = 34'sd256;
            5'd22: v = 34'sd128;
            5'd23: v = 34'sd64;
            5'd24: v = 34'sd32;
            5'd25: v = 34'sd16;
            5'd26: v = 34'sd8;
            5'd27: v = 34'sd4;
            5'd28: v = 34'sd2;
            5'd29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* src/rpba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rpba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/rpba_ctrl.sv */
// Sequencer for loading, the matrix build pass and result emission.
`timescale 1ns / 1ps
module rpba_ctrl import rpba_pkg::*; #(
    parameter int MAX_ATOMS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           last_atom,
    output logic                           in_ready,
    output logic                           out_valid,
    input  logic                           out_ready,
    input  stat_t                          stat,
    output cmd_t                           cmd,
    output logic [$clog2(MAX_ATOMS)-1:0]   k,
    output logic [$clog2(MAX_ATOMS+1)-1:0] count
);

    localparam int AW   = $clog2(MAX_ATOMS);
    localparam int CNTW = $clog2(MAX_ATOMS + 1);

    st_t             state_reg, state_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic [1:0]      sel_reg, sel_next;
    logic [AW-1:0]   k_reg, k_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            acc_in, full, last_now;

    assign acc_in   = in_valid && (state_reg == S_LOAD);
    assign full     = (count_reg == CNTW'(MAX_ATOMS));
    assign last_now = ((CNTW'(k_reg) + CNTW'(1)) == count_reg);
    assign k        = k_reg;
    assign count    = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            sel_reg   <= '0;
            k_reg     <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            k_reg     <= k_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        k_next     = k_reg;
        count_next = count_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (acc_in)
                begin
                    if (!full)
                    begin
                        count_next = count_reg + CNTW'(1);
                    end
                    if (last_atom)
                    begin
                        state_next = S_RD_PIV;
                    end
                end
            end
            S_RD_PIV:  state_next = S_RD_AXIS;
            S_RD_AXIS: state_next = S_DIFF;
            S_DIFF:    state_next = S_CHECK;
            S_CHECK:
            begin
                k_next     = '0;
                state_next = stat.ok_now ? S_NORM : S_EM_RD;
            end
            S_NORM:
            begin
                cnt_next = '0;
                if (stat.norm_done)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    sel_next   = '0;
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:
            begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END:
            begin
                if (sel_reg == LANE_LAST)
                begin
                    state_next = S_CORDIC_INIT;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_DIV_INIT;
                end
            end
            S_CORDIC_INIT:
            begin
                cnt_next   = '0;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == CORDIC_LAST)
                begin
                    state_next = S_CS;
                end
            end
            S_CS:
            begin
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_MAT;
                end
            end
            S_MAT:
            begin
                k_next     = '0;
                state_next = S_EM_RD;
            end
            S_EM_RD: state_next = S_EM_CAP;
            S_EM_CAP:
            begin
                cnt_next   = '0;
                sel_next   = '0;
                state_next = stat.move_now ? S_EM_MUL : S_EM_OUT;
            end
            S_EM_MUL: state_next = S_EM_ACC;
            S_EM_ACC:
            begin
                state_next = S_EM_MUL;
                if (cnt_reg[1:0] != LANE_LAST)
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
                else if (sel_reg != LANE_LAST)
                begin
                    cnt_next = '0;
                    sel_next = sel_reg + 2'd1;
                end
                else
                begin
                    state_next = S_EM_OUT;
                end
            end
            S_EM_OUT: state_next = S_EM_WAIT;
            S_EM_WAIT:
            begin
                if (out_ready)
                begin
                    if (last_now)
                    begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        state_next = S_EM_RD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        cmd.cnt   = cnt_reg;
        cmd.sel   = sel_reg;
        cmd.load  = acc_in && !full;
        cmd.last  = last_now;
        in_ready  = (state_reg == S_LOAD);
        out_valid = (state_reg == S_EM_WAIT);
        unique case (state_reg)
            S_RD_PIV:      cmd.op = OP_RD_PIV;
            S_RD_AXIS:     cmd.op = OP_RD_AXIS;
            S_DIFF:        cmd.op = OP_DIFF;
            S_CHECK:       cmd.op = OP_CHECK;
            S_NORM:        cmd.op = OP_NORM;
            S_SQ:          cmd.op = OP_SQ;
            S_SQRT:        cmd.op = OP_SQRT;
            S_DIV_INIT:    cmd.op = OP_DIV_INIT;
            S_DIV:         cmd.op = OP_DIV;
            S_DIV_END:     cmd.op = OP_DIV_END;
            S_CORDIC_INIT: cmd.op = OP_CORDIC_INIT;
            S_CORDIC:      cmd.op = OP_CORDIC;
            S_CS:          cmd.op = OP_CS;
            S_MUL:         cmd.op = OP_MUL;
            S_MAT:         cmd.op = OP_MAT;
            S_EM_RD:       cmd.op = OP_EM_RD;
            S_EM_CAP:      cmd.op = OP_EM_CAP;
            S_EM_MUL:      cmd.op = OP_EM_MUL;
            S_EM_ACC:      cmd.op = OP_EM_ACC;
            S_EM_OUT:      cmd.op = OP_EM_OUT;
            default:       cmd.op = OP_IDLE;
        endcase
    end

endmodule

/* src/rpba_dp.sv */
// Datapath: atom store, axis normalization, CORDIC, matrix build and rotation.
`timescale 1ns / 1ps
module rpba_dp import rpba_pkg::*; #(
    parameter int MAX_ATOMS   = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cmd_t                           cmd,
    output stat_t                          stat,
    input  logic [$clog2(MAX_ATOMS)-1:0]   k,
    input  logic [$clog2(MAX_ATOMS+1)-1:0] count,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,
    input  logic signed [31:0]             x_in,
    input  logic signed [31:0]             y_in,
    input  logic signed [31:0]             z_in,
    input  logic [7:0]                     side_tag,
    output logic signed [31:0]             x_out,
    output logic signed [31:0]             y_out,
    output logic signed [31:0]             z_out,
    output logic                           was_moved,
    output logic                           axis_error,
    output logic                           last_out
);

    localparam int CW   = COORD_WIDTH;
    localparam int AW   = $clog2(MAX_ATOMS);
    localparam int RW   = 3 * CW + 8;
    localparam longint SAT_HI_L = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAT_HI_L);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] E_HI   = 37'sd1073741824;
    localparam logic signed [ACC_W-1:0] E_LO   = -37'sd1073741824;

    // Configuration registers.
    logic signed [31:0] angle_reg;
    logic [7:0]         side_reg;
    logic [IDX_W-1:0]   pivot_reg, axis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= '0;
            side_reg  <= 8'd1;
            pivot_reg <= '0;
            axis_reg  <= IDX_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ANGLE: angle_reg <= cfg_data;
                REG_SIDE:  side_reg  <= cfg_data[7:0];
                REG_PIVOT: pivot_reg <= cfg_data[IDX_W-1:0];
                REG_AXIS:  axis_reg  <= cfg_data[IDX_W-1:0];
                default:   angle_reg <= angle_reg;
            endcase
        end
    end

    // Atom store.
    logic [AW-1:0]         raddr;
    logic [RW-1:0]         rdata;
    logic signed [CW-1:0]  rd_c [3];
    logic [7:0]            rd_tag;

    always_comb
    begin
        unique case (cmd.op)
            OP_RD_PIV:  raddr = pivot_reg[AW-1:0];
            OP_RD_AXIS: raddr = axis_reg[AW-1:0];
            default:    raddr = k;
        endcase
    end

    rpba_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_ATOMS)
    ) u_store (
        .clk  (clk),
        .we   (cmd.load),
        .waddr(count[AW-1:0]),
        .wdata({side_tag, z_in[CW-1:0], y_in[CW-1:0], x_in[CW-1:0]}),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign rd_c[0] = rdata[CW-1:0];
    assign rd_c[1] = rdata[2*CW-1:CW];
    assign rd_c[2] = rdata[3*CW-1:2*CW];
    assign rd_tag  = rdata[RW-1:3*CW];

    // Working registers.
    logic signed [CW-1:0]     piv_reg [3];
    logic [MAG_W-1:0]         mag_reg [3];
    logic                     neg_reg [3];
    logic                     ok_reg, move_reg, flip_reg;
    logic [SUM_W-1:0]         sum_reg, res_reg;
    logic [LEN_W-1:0]         rem_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic signed [OPW-1:0]    u_reg [3];
    logic signed [CORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [OPW-1:0]    c_reg, s_reg, t_reg, tmp_reg;
    logic signed [MW-1:0]     a_reg [6];
    logic signed [MW-1:0]     b_reg [3];
    logic signed [MAT_W-1:0]  mat_reg [3][3];
    logic signed [CW-1:0]     p_reg [3];
    logic signed [CW:0]       dq_reg [3];
    logic signed [34:0]       prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [CW-1:0]     r_reg [3];

    // Axis difference and magnitudes.
    logic signed [CW:0] d [3];
    logic [CW:0]        dabs [3];
    logic [MAG_W-1:0]   m01, mmax;
    logic               ok_idx;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            d[j]    = (CW+1)'(piv_reg[j]) - (CW+1)'(rd_c[j]);
            dabs[j] = d[j][CW] ? -d[j] : d[j];
        end
    end

    assign m01    = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
    assign mmax   = (m01 > mag_reg[2]) ? m01 : mag_reg[2];
    assign ok_idx = ({1'b0, pivot_reg} < CMP_W'(count)) && ({1'b0, axis_reg} < CMP_W'(count));

    assign stat.norm_done = (mmax[MAG_W-1:31] == '0) && mmax[30];
    assign stat.ok_now    = ok_idx && (mmax != '0);
    assign stat.move_now  = ok_reg && (rd_tag == side_reg);

    // Sum of squares and square root step.
    logic [30:0]      sq_op;
    logic [61:0]      sq;
    logic [SUM_W-1:0] sbit, trial;

    assign sq_op = mag_reg[cmd.cnt[1:0]][30:0];
    assign sq    = sq_op * sq_op;
    assign sbit  = SUM_W'(1) << (6'd62 - {cmd.cnt, 1'b0});
    assign trial = res_reg + sbit;

    // Restoring division step.
    logic             div_in;
    logic [LEN_W:0]   rem2, len_ext;
    logic signed [OPW-1:0] quo_s;

    assign div_in  = (cmd.cnt == '0) ? mag_reg[cmd.sel][0] : 1'b0;
    assign rem2    = {rem_reg, div_in};
    assign len_ext = {1'b0, res_reg[LEN_W-1:0]};
    assign quo_s   = $signed({3'b000, quo_reg});

    // CORDIC step.
    logic signed [CORD_W-1:0] ang, xs, ys, atn, c_new;

    assign ang   = CORD_W'(angle_reg);
    assign xs    = cx_reg >>> cmd.cnt;
    assign ys    = cy_reg >>> cmd.cnt;
    assign atn   = atan_q29(cmd.cnt);
    assign c_new = flip_reg ? -cx_reg : cx_reg;

    // Shared multiplier for the matrix terms.
    logic signed [OPW-1:0]     opa, opb;
    logic signed [2*OPW-1:0]   mprod;
    logic [1:0]                bidx;

    assign bidx = 2'(cmd.cnt - MUL_B_FIRST);

    always_comb
    begin
        opa = tmp_reg;
        opb = t_reg;
        case (cmd.cnt)
            5'd0:  begin opa = u_reg[0]; opb = u_reg[0]; end
            5'd2:  begin opa = u_reg[1]; opb = u_reg[1]; end
            5'd4:  begin opa = u_reg[2]; opb = u_reg[2]; end
            5'd6:  begin opa = u_reg[0]; opb = u_reg[1]; end
            5'd8:  begin opa = u_reg[0]; opb = u_reg[2]; end
            5'd10: begin opa = u_reg[1]; opb = u_reg[2]; end
            5'd12: begin opa = u_reg[0]; opb = s_reg; end
            5'd13: begin opa = u_reg[1]; opb = s_reg; end
            5'd14: begin opa = u_reg[2]; opb = s_reg; end
            default: begin opa = tmp_reg; opb = t_reg; end
        endcase
    end

    assign mprod = opa * opb;

    // Matrix entries before clamping.
    logic signed [ACC_W-1:0] e [9];
    logic signed [ACC_W-1:0] c_ext;

    assign c_ext = ACC_W'(c_reg);

    always_comb
    begin
        e[0] = c_ext + ACC_W'(a_reg[0]);
        e[4] = c_ext + ACC_W'(a_reg[1]);
        e[8] = c_ext + ACC_W'(a_reg[2]);
        e[1] = ACC_W'(a_reg[3]) - ACC_W'(b_reg[2]);
        e[3] = ACC_W'(a_reg[3]) + ACC_W'(b_reg[2]);
        e[2] = ACC_W'(a_reg[4]) + ACC_W'(b_reg[1]);
        e[6] = ACC_W'(a_reg[4]) - ACC_W'(b_reg[1]);
        e[5] = ACC_W'(a_reg[5]) - ACC_W'(b_reg[0]);
        e[7] = ACC_W'(a_reg[5]) + ACC_W'(b_reg[0]);
    end

    function automatic logic signed [MAT_W-1:0] clamp_one(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] w;
        w = (v > E_HI) ? E_HI : ((v < E_LO) ? E_LO : v);
        return MAT_W'(w);
    endfunction

    // Rotation multiply and accumulate.
    logic signed [MAT_W-1:0]  rop;
    logic signed [32:0]       qop;
    logic signed [64:0]       rprod;
    logic signed [ACC_W-1:0]  rbase, rsum;
    logic signed [CW-1:0]     rsat;

    assign rop   = mat_reg[cmd.sel][cmd.cnt[1:0]];
    assign qop   = 33'(dq_reg[cmd.cnt[1:0]]);
    assign rprod = rop * qop;
    assign rbase = (cmd.cnt == '0) ? ACC_W'(piv_reg[cmd.sel]) : acc_reg;
    assign rsum  = rbase + ACC_W'(prod_reg);
    assign rsat  = (rsum > SAT_HI) ? CW'(SAT_HI) : ((rsum < SAT_LO) ? CW'(SAT_LO) : CW'(rsum));

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_RD_AXIS:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    piv_reg[j] <= rd_c[j];
                end
            end
            OP_DIFF:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    mag_reg[j] <= MAG_W'(dabs[j]);
                    neg_reg[j] <= d[j][CW];
                end
                sum_reg <= '0;
                res_reg <= '0;
            end
            OP_CHECK: ok_reg <= stat.ok_now;
            OP_NORM:
            begin
                // A right shift by one bit moves an oversized axis toward range; a short one is shifted left.
                if (mmax[MAG_W-1:31] != '0)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        mag_reg[j] <= mag_reg[j] >> 1;
                    end
                end
                else if (!mmax[30])
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        mag_reg[j] <= mag_reg[j] << 1;
                    end
                end
            end
            OP_SQ: sum_reg <= sum_reg + SUM_W'(sq);
            OP_SQRT:
            begin
                if (sum_reg >= trial)
                begin
                    sum_reg <= sum_reg - trial;
                    res_reg <= (res_reg >> 1) + sbit;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
            end
            OP_DIV_INIT:
            begin
                rem_reg <= LEN_W'(mag_reg[cmd.sel][31:1]);
                quo_reg <= '0;
            end
            OP_DIV:
            begin
                if (rem2 >= len_ext)
                begin
                    rem_reg <= LEN_W'(rem2 - len_ext);
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[LEN_W-1:0];
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                end
            end
            OP_DIV_END: u_reg[cmd.sel] <= neg_reg[cmd.sel] ? -quo_s : quo_s;
            OP_CORDIC_INIT:
            begin
                cx_reg <= GAIN_Q30;
                cy_reg <= '0;
                if (ang > HALF_PI_Q29)
                begin
                    cz_reg   <= ang - PI_Q29;
                    flip_reg <= 1'b1;
                end
                else if (ang < -HALF_PI_Q29)
                begin
                    cz_reg   <= ang + PI_Q29;
                    flip_reg <= 1'b1;
                end
                else
                begin
                    cz_reg   <= ang;
                    flip_reg <= 1'b0;
                end
            end
            OP_CORDIC:
            begin
                if (!cz_reg[CORD_W-1])
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atn;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atn;
                end
            end
            OP_CS:
            begin
                c_reg <= c_new;
                s_reg <= flip_reg ? -cy_reg : cy_reg;
                t_reg <= ONE_Q30 - c_new;
            end
            OP_MUL:
            begin
                if (cmd.cnt >= MUL_B_FIRST)
                begin
                    b_reg[bidx] <= mprod[MW+29:30];
                end
                else if (!cmd.cnt[0])
                begin
                    tmp_reg <= mprod[OPW+29:30];
                end
                else
                begin
                    a_reg[3'(cmd.cnt[4:1])] <= mprod[MW+29:30];
                end
            end
            OP_MAT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        mat_reg[i][j] <= clamp_one(e[3*i+j]);
                    end
                end
            end
            OP_EM_CAP:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p_reg[j]  <= rd_c[j];
                    dq_reg[j] <= (CW+1)'(rd_c[j]) - (CW+1)'(piv_reg[j]);
                end
                move_reg <= stat.move_now;
            end
            OP_EM_MUL: prod_reg <= rprod[64:30];
            OP_EM_ACC:
            begin
                acc_reg <= rsum;
                if (cmd.cnt[1:0] == LANE_LAST)
                begin
                    r_reg[cmd.sel] <= rsat;
                end
            end
            OP_EM_OUT:
            begin
                x_out      <= move_reg ? 32'(r_reg[0]) : 32'(p_reg[0]);
                y_out      <= move_reg ? 32'(r_reg[1]) : 32'(p_reg[1]);
                z_out      <= move_reg ? 32'(r_reg[2]) : 32'(p_reg[2]);
                was_moved  <= move_reg;
                axis_error <= !ok_reg;
                last_out   <= cmd.last;
            end
            default: ok_reg <= ok_reg;
        endcase
    end

endmodule

/* src/rotate_points_about_bond_axis.sv */
// Top level of the bond-axis rotation block: sequencer, datapath and checks.
//
// Atoms arrive on the input channel, one transaction per atom and one per
// cycle while in_ready is high; each carries x/y/z in Q16.16 and a side tag.
// The transaction with last_atom set closes the set. The block then reads the
// pivot and axis atoms and checks them; on a failed check it skips to
// emission. Otherwise it normalizes the axis, sums the squares, takes the
// square root, divides three times, runs the CORDIC and builds the matrix on
// one shared multiplier. Results follow in load order; each rotated atom takes
// nine products on the single multiply-accumulate unit, while an unmoved atom
// skips them. in_ready stays low from the last atom until the final result
// transaction is taken. A stalled receiver simply holds the output register;
// nothing is lost. Reset clears the atom count and the sequencer and loads the
// register defaults (angle 0, side value 1, pivot 0, axis 1). Registers are
// written through cfg_we, cfg_index and cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`include "rotate_points_about_bond_axis_macros.svh"
module rotate_points_about_bond_axis import rpba_pkg::*; #(
    parameter int MAX_ATOMS   = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] x_in,
    input  logic signed [31:0] y_in,
    input  logic signed [31:0] z_in,
    input  logic [7:0]         side_tag,
    input  logic               last_atom,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] x_out,
    output logic signed [31:0] y_out,
    output logic signed [31:0] z_out,
    output logic               was_moved,
    output logic               axis_error,
    output logic               last_out,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    cmd_t                           cmd;
    stat_t                          stat;
    logic [$clog2(MAX_ATOMS)-1:0]   k;
    logic [$clog2(MAX_ATOMS+1)-1:0] count;

    rpba_ctrl #(
        .MAX_ATOMS(MAX_ATOMS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last_atom(last_atom),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .stat     (stat),
        .cmd      (cmd),
        .k        (k),
        .count    (count)
    );

    rpba_dp #(
        .MAX_ATOMS  (MAX_ATOMS),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .k         (k),
        .count     (count),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .x_in      (x_in),
        .y_in      (y_in),
        .z_in      (z_in),
        .side_tag  (side_tag),
        .x_out     (x_out),
        .y_out     (y_out),
        .z_out     (z_out),
        .was_moved (was_moved),
        .axis_error(axis_error),
        .last_out  (last_out)
    );

    `RPBA_ASSERT_SAME(a_load_emit_exclusive, in_ready, !out_valid, "load and emit overlap")
    `RPBA_ASSERT_NEXT(a_set_end_reloads, out_valid && out_ready && last_out, in_ready, "no reload after set")
    `RPBA_ASSERT_NEXT(a_last_stops_load, in_valid && in_ready && last_atom, !in_ready, "load after last atom")
    `RPBA_ASSERT_SAME(a_error_not_moved, out_valid && axis_error, !was_moved, "moved atom on axis error")

endmodule
